### rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 edge-normalized box blur.
// No dependencies.
package bb3_pkg;

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 12;
  localparam int DVD_W   = 13;
  localparam int NCNT_W  = 4;
  localparam int STEPS   = 13;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  typedef struct packed {
    logic clr;
    logic acc;
    logic start;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_START,
    S_DIV,
    S_HOLD
  } state_t;

endpackage

### rtl/box_blur_3x3_edge_normalized_core.sv
// Top level of the 3x3 edge-normalized box blur: control, history RAM, lanes, output.
// Depends on bb3_pkg, bb3_ram and bb3_lane.
// An item that releases an output holds off new items until its result is loaded
// into the output register, after up to 9 history reads on the single RAM read port
// and a 13-step lane divider; an item with no output leaves the control idle.
// Reset: synchronous, clears counters and control; history RAM is not cleared.
module box_blur_3x3_edge_normalized_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [bb3_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [7:0]                        pix_red,
  input  logic [7:0]                        pix_green,
  input  logic [7:0]                        pix_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        blur_red,
  output logic [7:0]                        blur_green,
  output logic [7:0]                        blur_blue,
  output logic                              frame_end
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DEPTH = 2 * MAX_WIDTH + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = $clog2(DEPTH + 1);

  logic [10:0] cfg_w;
  logic [12:0] cfg_h;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [MW-1:0] m;

  logic [CW-1:0] in_col, out_col, cur_col;
  logic [RW-1:0] in_row, out_row, cur_row;
  logic [LW-1:0] in_lin, out_lin;
  logic [MW-1:0] in_slot, out_slot, cur_slot;

  bb3_pkg::state_t state, state_next;
  bb3_pkg::lane_ctl_t lctl;

  logic [1:0] dr, dc;
  logic [bb3_pkg::NCNT_W-1:0] ncnt;
  logic rd_v;
  logic cur_end;

  logic accept, draining, is_pix, due;
  logic [LW:0] count, need;
  logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
  logic row_ok, col_ok, inb, last_tap;
  logic [MW+1:0] t_raw, t_red;
  logic [23:0] rdata;
  logic [7:0] mean_r, mean_g, mean_b;
  logic busy_r, busy_g, busy_b;
  logic load_out;

  always_comb begin
    if (cfg_w == 11'd0) begin
      w = WW'(1);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg_w);
    end
    if (cfg_h == 13'd0) begin
      h = HW'(1);
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg_h);
    end
    m = MW'(2 * 32'(w) + 3);
  end

  assign accept   = in_valid && in_ready;
  assign draining = (in_lin == '0) && (out_lin != '0);
  assign is_pix   = !req_type && !draining;
  assign count    = (LW + 1)'(in_lin) + (LW + 1)'(is_pix);
  assign need     = (LW + 1)'(out_lin)
                  + ((32'(out_row) + 1 < 32'(h)) ? (LW + 1)'(w) : '0)
                  + ((32'(out_col) + 1 < 32'(w)) ? (LW + 1)'(1) : '0);
  assign due      = draining || (need < count);

  assign in_col_wrap  = 32'(in_col) + 1 >= 32'(w);
  assign in_row_wrap  = 32'(in_row) + 1 >= 32'(h);
  assign out_col_wrap = 32'(out_col) + 1 >= 32'(w);
  assign out_row_wrap = 32'(out_row) + 1 >= 32'(h);

  always_comb begin
    unique case (dr)
      2'd0:    row_ok = cur_row != '0;
      2'd2:    row_ok = 32'(cur_row) + 1 < 32'(h);
      default: row_ok = 1'b1;
    endcase
    unique case (dc)
      2'd0:    col_ok = cur_col != '0;
      2'd2:    col_ok = 32'(cur_col) + 1 < 32'(w);
      default: col_ok = 1'b1;
    endcase
    t_raw = (MW + 2)'(cur_slot) + (MW + 2)'(32'(dr) * 32'(w)) + (MW + 2)'(dc)
          + (MW + 2)'(w) + (MW + 2)'(2);
    if (t_raw >= (MW + 2)'({m, 1'b0})) begin
      t_red = t_raw - (MW + 2)'({m, 1'b0});
    end else if (t_raw >= (MW + 2)'(m)) begin
      t_red = t_raw - (MW + 2)'(m);
    end else begin
      t_red = t_raw;
    end
  end

  assign inb      = (state == bb3_pkg::S_READ) && row_ok && col_ok;
  assign last_tap = (dr == 2'd2) && (dc == 2'd2);
  assign load_out = ((state == bb3_pkg::S_DIV && !busy_r) || state == bb3_pkg::S_HOLD)
                  && (!out_valid || out_ready);

  bb3_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (accept && is_pix),
    .waddr (in_slot[AW-1:0]),
    .wdata ({pix_red, pix_green, pix_blue}),
    .re    (inb),
    .raddr (t_red[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    lctl.clr   = accept && due;
    lctl.acc   = rd_v;
    lctl.start = state == bb3_pkg::S_START;
  end

  bb3_lane u_red (
    .clk(clk), .rst(rst), .ctl(lctl), .pix(rdata[23:16]), .ncnt(ncnt),
    .mean(mean_r), .busy(busy_r)
  );
  bb3_lane u_green (
    .clk(clk), .rst(rst), .ctl(lctl), .pix(rdata[15:8]), .ncnt(ncnt),
    .mean(mean_g), .busy(busy_g)
  );
  bb3_lane u_blue (
    .clk(clk), .rst(rst), .ctl(lctl), .pix(rdata[7:0]), .ncnt(ncnt),
    .mean(mean_b), .busy(busy_b)
  );

  always_comb begin
    state_next = state;
    in_ready   = state == bb3_pkg::S_IDLE;
    unique case (state)
      bb3_pkg::S_IDLE: begin
        if (accept && due) begin
          state_next = bb3_pkg::S_READ;
        end
      end
      bb3_pkg::S_READ: begin
        if (last_tap) begin
          state_next = bb3_pkg::S_ACC;
        end
      end
      bb3_pkg::S_ACC:   state_next = bb3_pkg::S_START;
      bb3_pkg::S_START: state_next = bb3_pkg::S_DIV;
      bb3_pkg::S_DIV: begin
        if (!busy_r) begin
          state_next = load_out ? bb3_pkg::S_IDLE : bb3_pkg::S_HOLD;
        end
      end
      bb3_pkg::S_HOLD: begin
        if (load_out) begin
          state_next = bb3_pkg::S_IDLE;
        end
      end
      default: state_next = bb3_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bb3_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= 11'd640;
      cfg_h    <= 13'd480;
      in_col   <= '0;
      in_row   <= '0;
      in_lin   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_lin  <= '0;
      out_slot <= '0;
      rd_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v <= inb;
      if (cfg_we && (cfg_addr == bb3_pkg::REG_FRAME_WIDTH ||
                     cfg_addr == bb3_pkg::REG_FRAME_HEIGHT)) begin
        if (cfg_addr == bb3_pkg::REG_FRAME_WIDTH) begin
          cfg_w <= cfg_data[10:0];
        end else begin
          cfg_h <= cfg_data;
        end
        in_col   <= '0;
        in_row   <= '0;
        in_lin   <= '0;
        in_slot  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_lin  <= '0;
        out_slot <= '0;
      end else if (accept) begin
        if (is_pix) begin
          if (in_col_wrap) begin
            in_col <= '0;
            if (in_row_wrap) begin
              in_row  <= '0;
              in_lin  <= '0;
              in_slot <= '0;
            end else begin
              in_row  <= in_row + RW'(1);
              in_lin  <= in_lin + LW'(1);
              in_slot <= (in_slot + MW'(1) == m) ? '0 : in_slot + MW'(1);
            end
          end else begin
            in_col  <= in_col + CW'(1);
            in_lin  <= in_lin + LW'(1);
            in_slot <= (in_slot + MW'(1) == m) ? '0 : in_slot + MW'(1);
          end
        end
        if (due) begin
          if (out_col_wrap) begin
            out_col <= '0;
            if (out_row_wrap) begin
              out_row  <= '0;
              out_lin  <= '0;
              out_slot <= '0;
            end else begin
              out_row  <= out_row + RW'(1);
              out_lin  <= out_lin + LW'(1);
              out_slot <= (out_slot + MW'(1) == m) ? '0 : out_slot + MW'(1);
            end
          end else begin
            out_col  <= out_col + CW'(1);
            out_lin  <= out_lin + LW'(1);
            out_slot <= (out_slot + MW'(1) == m) ? '0 : out_slot + MW'(1);
          end
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && due) begin
      cur_row  <= out_row;
      cur_col  <= out_col;
      cur_slot <= out_slot;
      cur_end  <= out_col_wrap && out_row_wrap;
      dr       <= 2'd0;
      dc       <= 2'd0;
      ncnt     <= '0;
    end else if (state == bb3_pkg::S_READ) begin
      if (inb) begin
        ncnt <= ncnt + bb3_pkg::NCNT_W'(1);
      end
      if (dc == 2'd2) begin
        dc <= 2'd0;
        dr <= dr + 2'd1;
      end else begin
        dc <= dc + 2'd1;
      end
    end
    if (load_out) begin
      blur_red   <= mean_r;
      blur_green <= mean_g;
      blur_blue  <= mean_b;
      frame_end  <= cur_end;
    end
  end

`ifndef SYNTHESIS
  a_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    (busy_r || busy_g || busy_b) |-> (state == bb3_pkg::S_DIV))
    else $error("lane divider busy outside divide state");
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (busy_r == busy_g) && (busy_g == busy_b))
    else $error("lanes out of step");
  a_read_window: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (state == bb3_pkg::S_READ || state == bb3_pkg::S_ACC))
    else $error("history read data outside gather");
  a_ncnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == bb3_pkg::S_START) |-> (ncnt != '0 && ncnt <= 4'd9))
    else $error("neighbor count out of range");
`endif

endmodule

### rtl/bb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2051
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bb3_lane.sv
// One color lane: accumulates neighborhood samples and divides with rounding.
// Depends on bb3_pkg.
module bb3_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  bb3_pkg::lane_ctl_t              ctl,
  input  logic [bb3_pkg::PIX_W-1:0]       pix,
  input  logic [bb3_pkg::NCNT_W-1:0]      ncnt,
  output logic [bb3_pkg::PIX_W-1:0]       mean,
  output logic                            busy
);

  logic [bb3_pkg::SUM_W-1:0]  sum;
  logic [bb3_pkg::DVD_W-1:0]  dvd;
  logic [4:0]                 dvs;
  logic [4:0]                 rem;
  logic [5:0]                 rem_sh;
  logic                       ge;
  logic [3:0]                 steps;

  assign rem_sh = {rem, dvd[bb3_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign busy   = steps != 4'd0;
  assign mean   = dvd[bb3_pkg::PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= 4'd0;
    end else if (ctl.start) begin
      steps <= 4'(bb3_pkg::STEPS);
    end else if (busy) begin
      steps <= steps - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      sum <= '0;
    end else if (ctl.acc) begin
      sum <= sum + bb3_pkg::SUM_W'(pix);
    end
    if (ctl.start) begin
      dvd <= {sum, 1'b0} + bb3_pkg::DVD_W'(ncnt);
      dvs <= {ncnt, 1'b0};
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? 5'(rem_sh - {1'b0, dvs}) : rem_sh[4:0];
      dvd <= {dvd[bb3_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

### sim/tb_box_blur_3x3_edge_normalized_core.sv
// Testbench for the 3x3 edge-normalized box blur: random and directed frames
// checked against a built-in predictor of the neighborhood means.
// Depends on bb3_pkg and box_blur_3x3_edge_normalized_core.
`timescale 1ns / 1ps

module tb_box_blur_3x3_edge_normalized_core;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } blur_t;

  localparam int LINE_MAX = 1024;
  localparam int ROWS_MAX = 4096;
  localparam int DRAIN_SETTLE = 40;
  localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [bb3_pkg::CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [7:0] pix_red = '0, pix_green = '0, pix_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] blur_red, blur_green, blur_blue;
  logic frame_end;

  box_blur_3x3_edge_normalized_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [10:0] pw_reg = 11'd640;
  logic [12:0] ph_reg = 13'd480;
  logic [23:0] hist_lower [LINE_MAX];
  logic [23:0] hist_upper [LINE_MAX];
  logic [23:0] hist_win [9];
  int unsigned pin_row, pin_col, pout_row, pout_col;

  blur_t pending_blur [$];
  int mismatches = 0;
  int items_sent = 0;
  bit no_idle = 0;
  bit hold_start = 0;

  function automatic int unsigned eff_w();
    return (pw_reg < 1) ? 1 : (pw_reg > LINE_MAX) ? LINE_MAX : pw_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (ph_reg < 1) ? 1 : (ph_reg > ROWS_MAX) ? ROWS_MAX : ph_reg;
  endfunction

  function automatic logic [23:0] hist_rd(int unsigned lin, int unsigned w);
    int unsigned s;
    s = lin % (2 * w + 3);
    if (s < w) return hist_lower[s];
    if (s < 2 * w) return hist_upper[s - w];
    return hist_win[(s - 2 * w) % 9];
  endfunction

  function automatic void hist_wr(int unsigned lin, int unsigned w, logic [23:0] v);
    int unsigned s;
    s = lin % (2 * w + 3);
    if (s < w) hist_lower[s] = v;
    else if (s < 2 * w) hist_upper[s - w] = v;
    else hist_win[(s - 2 * w) % 9] = v;
  endfunction

  function automatic bit blur_predict(input bit drain, input logic [23:0] px,
                                      output blur_t res);
    int unsigned w, h, in_lin, out_lin, cnt, nr, nc, n;
    int unsigned s [3];
    logic [23:0] v;
    int rr, cc;
    w = eff_w();
    h = eff_h();
    in_lin = pin_row * w + pin_col;
    out_lin = pout_row * w + pout_col;
    res = '0;
    if (in_lin == 0 && out_lin != 0) begin
      cnt = w * h;
    end else if (!drain) begin
      hist_wr(in_lin, w, px);
      cnt = in_lin + 1;
      pin_col++;
      if (pin_col >= w) begin
        pin_col = 0;
        pin_row++;
        if (pin_row >= h) pin_row = 0;
      end
    end else begin
      cnt = in_lin;
    end
    nr = (pout_row + 1 < h) ? pout_row + 1 : pout_row;
    nc = (pout_col + 1 < w) ? pout_col + 1 : pout_col;
    if (nr * w + nc >= cnt) return 0;
    s = '{0, 0, 0};
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = int'(pout_row) + dr;
        cc = int'(pout_col) + dc;
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
          v = hist_rd(rr * w + cc, w);
          s[0] += v[23:16];
          s[1] += v[15:8];
          s[2] += v[7:0];
          n++;
        end
      end
    end
    res.red = 8'((2 * s[0] + n) / (2 * n));
    res.green = 8'((2 * s[1] + n) / (2 * n));
    res.blue = 8'((2 * s[2] + n) / (2 * n));
    res.fend = (pout_row == h - 1 && pout_col == w - 1);
    pout_col++;
    if (pout_col >= w) begin
      pout_col = 0;
      pout_row++;
      if (pout_row >= h) pout_row = 0;
    end
    return 1;
  endfunction

  function automatic bit frame_idle();
    return pin_row == 0 && pin_col == 0 && pout_row == 0 && pout_col == 0;
  endfunction

  // send one request; caller sits at a rising edge
  task automatic send_req(bit drain, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    blur_t res;
    int gap;
    in_valid <= 1'b1;
    req_type <= drain;
    pix_red <= r;
    pix_green <= g;
    pix_blue <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (blur_predict(drain, {r, g, b}, res)) pending_blur.push_back(res);
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_blur.size() == 0);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                           logic [bb3_pkg::CFG_DAT_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bb3_pkg::REG_FRAME_WIDTH) pw_reg = val[10:0];
    else if (idx == bb3_pkg::REG_FRAME_HEIGHT) ph_reg = val;
    if (idx == bb3_pkg::REG_FRAME_WIDTH || idx == bb3_pkg::REG_FRAME_HEIGHT) begin
      pin_row = 0; pin_col = 0; pout_row = 0; pout_col = 0;
    end
  endtask

  function automatic logic [7:0] chan(bit extreme);
    if (extreme) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // run one whole frame; drains mixed in at the given percentage
  task automatic run_frame(int drain_pct, bit extreme);
    bit first;
    first = 1;
    do begin
      send_req(!first && $urandom_range(0, 99) < drain_pct,
               chan(extreme), chan(extreme), chan(extreme));
      first = 0;
    end while (!frame_idle());
  endtask

  task automatic set_size(int w, int h);
    write_reg(bb3_pkg::REG_FRAME_WIDTH, bb3_pkg::CFG_DAT_W'(w));
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, bb3_pkg::CFG_DAT_W'(h));
  endtask

  task automatic test_tiny_frames();
    set_size(3, 3);
    run_frame(0, 1);
    set_size(1, 1);
    run_frame(0, 1);
    set_size(0, 0);
    run_frame(0, 1);
    set_size(1, 4);
    run_frame(20, 1);
    set_size(4, 1);
    run_frame(20, 0);
  endtask

  task automatic test_size_extremes();
    set_size(2047, 1);
    repeat (12) send_req(0, chan(0), chan(0), chan(0));
    set_size(1024, 4096);
    repeat (6) send_req(0, chan(1), chan(0), chan(1));
    set_size(2, 8191);
    repeat (10) send_req(0, chan(0), chan(1), chan(0));
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
    run_frame(0, 0);
  endtask

  task automatic test_drain_cases();
    set_size(3, 2);
    send_req(1, 8'h12, 8'h34, 8'h56);
    repeat (4) send_req(0, chan(0), chan(0), chan(0));
    repeat (2) send_req(1, 8'hFF, 8'hFF, 8'hFF);
    repeat (2) send_req(0, chan(0), chan(0), chan(0));
    while (!frame_idle()) send_req(0, 8'hAA, 8'h55, 8'hAA);
    send_req(1, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_unknown_reg();
    write_reg(REG_UNUSED, 13'h1FFF);
    run_frame(10, 0);
  endtask

  task automatic test_backpressure();
    set_size(8, 6);
    no_idle = 1;
    settle();
    hold_start = 1;
    run_frame(5, 0);
    no_idle = 0;
  endtask

  task automatic test_random_frames();
    while (items_sent < 1150) begin
      if ($urandom_range(0, 2) == 0 || frame_idle())
        if ($urandom_range(0, 9) == 0) set_size($urandom_range(1, 40), $urandom_range(1, 4));
        else set_size($urandom_range(1, 7), $urandom_range(1, 6));
      no_idle = ($urandom_range(0, 3) == 0);
      run_frame($urandom_range(0, 1) ? 0 : $urandom_range(5, 30), $urandom_range(0, 4) == 0);
    end
    no_idle = 0;
  endtask

  // result checker with random stalls and one long hold-off
  initial begin
    int stall, hold_left;
    blur_t got, want;
    stall = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = {blur_red, blur_green, blur_blue, frame_end};
        if (pending_blur.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_blur.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected r=%h g=%h b=%h end=%b, got r=%h g=%h b=%h end=%b",
                       want.red, want.green, want.blue, want.fend,
                       got.red, got.green, got.blue, got.fend);
          end
        end
        stall = no_idle ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (hold_start) begin
        hold_start = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tiny_frames();
    test_size_extremes();
    test_drain_cases();
    test_unknown_reg();
    test_backpressure();
    test_random_frames();
    settle();
    if (mismatches == 0 && pending_blur.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
